FILE: sv/gcdist_pkg.sv
// Shared constants and inter-cell bus types for the great-circle distance pipeline.
package gcdist_pkg;

    // Angle units of 2^-24 degree
    localparam logic [30:0] QUARTER_TURN = 31'd1509949440;
    localparam logic [32:0] HALF_TURN    = 33'd3019898880;
    localparam logic [32:0] THREE_QUART  = 33'd4529848320;
    localparam logic [32:0] FULL_TURN    = 33'd6039797760;

    // Degrees-to-radians scale minus 2^33, Q33
    localparam logic [29:0] RAD_FRAC = 30'd1005114442;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [22:0] RADIUS_RESET = 23'd6371000;

    localparam int SIN_TERMS  = 8;
    localparam int ATAN_TERMS = 40;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 30;
    localparam int LANES      = 4;

    // Sine series link
    typedef struct packed {
        logic        vld;
        logic [31:0] s;
        logic [30:0] t;
        logic [30:0] x;
        logic        neg;
    } sin_bus_t;

    // Dual square root link
    typedef struct packed {
        logic        vld;
        logic [61:0] rad_y;
        logic [61:0] rad_x;
        logic [32:0] rem_y;
        logic [32:0] rem_x;
        logic [30:0] root_y;
        logic [30:0] root_x;
        logic [30:0] h;
    } sqrt_bus_t;

    // Restoring divider link
    typedef struct packed {
        logic        vld;
        logic [32:0] rem;
        logic [32:0] den;
        logic [29:0] quo;
        logic [30:0] y;
    } div_bus_t;

    // Arctangent series link
    typedef struct packed {
        logic        vld;
        logic [29:0] q;
        logic [30:0] t;
        logic [30:0] y;
    } atan_bus_t;

endpackage

FILE: sv/gcdist_sin_cell.sv
// One nested factor of the sine series: t' = 1 - ((s*t) >> 30) / (2k(2k+1)), three stages.
module gcdist_sin_cell
    import gcdist_pkg::*;
#(
    parameter int K = 1
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  sin_bus_t din,
    output sin_bus_t dout
);

    localparam logic [8:0]  D   = 9'(2 * K * (2 * K + 1));
    localparam logic [63:0] M64 = (64'd1 << 32) / {55'd0, D};
    localparam logic [29:0] M   = M64[29:0];

    logic        a_vld_reg, b_vld_reg, c_vld_reg;
    logic [61:0] a_prod_reg;
    logic [31:0] a_s_reg, b_s_reg, c_s_reg;
    logic [30:0] a_x_reg, b_x_reg, c_x_reg;
    logic        a_neg_reg, b_neg_reg, c_neg_reg;
    logic [61:0] b_pm_reg;
    logic [31:0] b_p_reg;
    logic [30:0] c_t_reg;

    logic [61:0] a_prod_next;
    logic [31:0] b_p_next;
    logic [61:0] b_pm_next;
    logic [29:0] q0;
    logic [31:0] qd;
    logic [31:0] rmd;
    logic [31:0] quo;
    logic [30:0] c_t_next;

    // Stage A: s * t
    assign a_prod_next = {30'd0, din.s} * {31'd0, din.t};

    // Stage B: scale by reciprocal of the divisor
    assign b_p_next  = a_prod_reg[61:30];
    assign b_pm_next = {30'd0, b_p_next} * {32'd0, M};

    // Stage C: quotient estimate, one correction step
    always_comb
    begin
        q0       = b_pm_reg[61:32];
        qd       = 32'({2'd0, q0} * {23'd0, D});
        rmd      = b_p_reg - qd;
        quo      = (rmd >= {23'd0, D}) ? ({2'd0, q0} + 32'd1) : {2'd0, q0};
        c_t_next = ONE_Q30 - quo[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= din.vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= a_prod_next;
            a_s_reg    <= din.s;
            a_x_reg    <= din.x;
            a_neg_reg  <= din.neg;
            b_pm_reg   <= b_pm_next;
            b_p_reg    <= b_p_next;
            b_s_reg    <= a_s_reg;
            b_x_reg    <= a_x_reg;
            b_neg_reg  <= a_neg_reg;
            c_t_reg    <= c_t_next;
            c_s_reg    <= b_s_reg;
            c_x_reg    <= b_x_reg;
            c_neg_reg  <= b_neg_reg;
        end
    end

    always_comb
    begin
        dout.vld = c_vld_reg;
        dout.s   = c_s_reg;
        dout.t   = c_t_reg;
        dout.x   = c_x_reg;
        dout.neg = c_neg_reg;
    end

endmodule

FILE: sv/gcdist_sqrt_cell.sv
// One digit step of two floor square roots carried side by side.
module gcdist_sqrt_cell
    import gcdist_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  sqrt_bus_t din,
    output sqrt_bus_t dout
);

    logic      vld_reg;
    sqrt_bus_t pay_reg;
    sqrt_bus_t pay_next;

    logic [34:0] rem4_y, rem4_x;
    logic [34:0] trial_y, trial_x;
    logic        ge_y, ge_x;

    // Bring down the next radicand pair and try the next root bit
    always_comb
    begin
        rem4_y  = {din.rem_y, din.rad_y[61:60]};
        rem4_x  = {din.rem_x, din.rad_x[61:60]};
        trial_y = {2'd0, din.root_y, 2'b01};
        trial_x = {2'd0, din.root_x, 2'b01};
        ge_y    = rem4_y >= trial_y;
        ge_x    = rem4_x >= trial_x;

        pay_next        = din;
        pay_next.vld    = din.vld;
        pay_next.rad_y  = {din.rad_y[59:0], 2'b00};
        pay_next.rad_x  = {din.rad_x[59:0], 2'b00};
        pay_next.rem_y  = ge_y ? 33'(rem4_y - trial_y) : rem4_y[32:0];
        pay_next.rem_x  = ge_x ? 33'(rem4_x - trial_x) : rem4_x[32:0];
        pay_next.root_y = {din.root_y[29:0], ge_y};
        pay_next.root_x = {din.root_x[29:0], ge_x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= din.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg <= pay_next;
        end
    end

    always_comb
    begin
        dout     = pay_reg;
        dout.vld = vld_reg;
    end

endmodule

FILE: sv/gcdist_div_cell.sv
// One quotient bit of the restoring divider for the arctangent argument.
module gcdist_div_cell
    import gcdist_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  div_bus_t din,
    output div_bus_t dout
);

    logic     vld_reg;
    div_bus_t pay_reg;
    div_bus_t pay_next;

    logic [33:0] rem2;
    logic        ge;

    // Shift the partial remainder and subtract where it fits
    always_comb
    begin
        rem2         = {din.rem, 1'b0};
        ge           = rem2 >= {1'b0, din.den};
        pay_next     = din;
        pay_next.rem = ge ? 33'(rem2 - {1'b0, din.den}) : rem2[32:0];
        pay_next.quo = {din.quo[28:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= din.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg <= pay_next;
        end
    end

    always_comb
    begin
        dout     = pay_reg;
        dout.vld = vld_reg;
    end

endmodule

FILE: sv/gcdist_atan_cell.sv
// One nested factor of the arctangent series: t' = 1 + ((q*t)>>30)*2k/(2k+1), three stages.
module gcdist_atan_cell
    import gcdist_pkg::*;
#(
    parameter int K = 1
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  atan_bus_t din,
    output atan_bus_t dout
);

    localparam logic [6:0]  D   = 7'(2 * K + 1);
    localparam logic [63:0] M64 = (64'd1 << 31) / {57'd0, D};
    localparam logic [29:0] M   = M64[29:0];

    logic        a_vld_reg, b_vld_reg, c_vld_reg;
    logic [60:0] a_prod_reg;
    logic [29:0] a_q_reg, b_q_reg, c_q_reg;
    logic [30:0] a_y_reg, b_y_reg, c_y_reg;
    logic [60:0] b_nm_reg;
    logic [29:0] b_p_reg;
    logic [30:0] c_t_reg;

    logic [60:0] a_prod_next;
    logic [29:0] b_p_next;
    logic [30:0] b_n_next;
    logic [60:0] b_nm_next;
    logic [30:0] n_c;
    logic [29:0] q0;
    logic [30:0] qd;
    logic [30:0] rmd;
    logic [30:0] ceil_q;
    logic [30:0] c_t_next;

    // Stage A: q * t
    assign a_prod_next = {31'd0, din.q} * {30'd0, din.t};

    // Stage B: p*2k/(2k+1) = p - ceil(p/(2k+1)); scale p+2k by the reciprocal
    assign b_p_next  = a_prod_reg[59:30];
    assign b_n_next  = {1'b0, b_p_next} + 31'(D - 7'd1);
    assign b_nm_next = {30'd0, b_n_next} * {31'd0, M};

    // Stage C: ceiling quotient with one correction step
    always_comb
    begin
        n_c      = {1'b0, b_p_reg} + 31'(D - 7'd1);
        q0       = b_nm_reg[60:31];
        qd       = 31'({1'b0, q0} * {24'd0, D});
        rmd      = n_c - qd;
        ceil_q   = (rmd >= {24'd0, D}) ? ({1'b0, q0} + 31'd1) : {1'b0, q0};
        c_t_next = ONE_Q30 + {1'b0, b_p_reg} - ceil_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= din.vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= a_prod_next;
            a_q_reg    <= din.q;
            a_y_reg    <= din.y;
            b_nm_reg   <= b_nm_next;
            b_p_reg    <= b_p_next;
            b_q_reg    <= a_q_reg;
            b_y_reg    <= a_y_reg;
            c_t_reg    <= c_t_next;
            c_q_reg    <= b_q_reg;
            c_y_reg    <= b_y_reg;
        end
    end

    always_comb
    begin
        dout.vld = c_vld_reg;
        dout.q   = c_q_reg;
        dout.t   = c_t_reg;
        dout.y   = c_y_reg;
    end

endmodule

FILE: sv/great_circle_distance_top.sv
// Haversine great-circle distance pipeline: top level with sine lanes and output buffer.
//
// Takes one position pair per clock while the pipeline is not held and returns its
// great-circle distance in meters with 4 fraction bits. The datapath is a pipeline
// of 219 stages (four sine lanes with 8 series cells each, a 31-cell dual square root,
// a 30-cell divider and 40 arctangent series cells) ahead of the output register. A
// two-entry output buffer lets the pipeline keep taking requests while one result
// waits; the whole pipeline holds only once both entries are full and m_axis_tready
// is low. The earth radius register is taken from cfg_data when cfg_valid is high and
// must be written only while no request is in flight.
module great_circle_distance_top
    import gcdist_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // cfg_data: earth_radius_m[22:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [22:0]  cfg_data,
    // s_axis_tdata: lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94], zero [127:126]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    // m_axis_tdata: distance[28:0], zero [31:29]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata
);

    logic en;

    // Radius register
    logic [22:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            radius_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // Lane angles: half lat difference, half lon difference, cos of lat_a, cos of lat_b
    logic [33:0] lat_a_x, lon_a_x, lat_b_x, lon_b_x;
    logic [33:0] ang_next [LANES];

    always_comb
    begin
        lat_a_x     = {{3{s_axis_tdata[30]}}, s_axis_tdata[30:0]};
        lon_a_x     = {{2{s_axis_tdata[62]}}, s_axis_tdata[62:31]};
        lat_b_x     = {{3{s_axis_tdata[93]}}, s_axis_tdata[93:63]};
        lon_b_x     = {{2{s_axis_tdata[125]}}, s_axis_tdata[125:94]};
        ang_next[0] = lat_b_x - lat_a_x;
        ang_next[1] = lon_b_x - lon_a_x;
        ang_next[2] = {lat_a_x[32:0], 1'b0} + {3'd0, QUARTER_TURN};
        ang_next[3] = {lat_b_x[32:0], 1'b0} + {3'd0, QUARTER_TURN};
    end

    // Sine front end registers
    logic        f1_vld_reg, f2_vld_reg, f3_vld_reg, f4_vld_reg;
    logic        f5_vld_reg, f6_vld_reg, f7_vld_reg;
    logic [33:0] ang_reg   [LANES];
    logic [32:0] red_reg   [LANES];
    logic [1:0]  quad_reg  [LANES];
    logic [30:0] frac_reg  [LANES];
    logic [30:0] u4_reg    [LANES];
    logic        neg4_reg  [LANES];
    logic [60:0] up_reg    [LANES];
    logic [30:0] u5_reg    [LANES];
    logic        neg5_reg  [LANES];
    logic [30:0] x6_reg    [LANES];
    logic        neg6_reg  [LANES];
    logic [31:0] s7_reg    [LANES];
    logic [30:0] x7_reg    [LANES];
    logic        neg7_reg  [LANES];

    logic [32:0] red_next  [LANES];
    logic [1:0]  quad_next [LANES];
    logic [32:0] base_sel  [LANES];
    logic [32:0] frac_full [LANES];
    logic [61:0] xx_next   [LANES];

    // Reduce to one turn, find quadrant and fold into the first quadrant; square the scaled argument
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            red_next[l] = ang_reg[l][33] ? 33'(ang_reg[l] + {1'b0, FULL_TURN})
                                         : ang_reg[l][32:0];
            if (red_reg[l] >= THREE_QUART)
            begin
                quad_next[l] = 2'd3;
                base_sel[l]  = THREE_QUART;
            end
            else if (red_reg[l] >= HALF_TURN)
            begin
                quad_next[l] = 2'd2;
                base_sel[l]  = HALF_TURN;
            end
            else if (red_reg[l] >= {2'd0, QUARTER_TURN})
            begin
                quad_next[l] = 2'd1;
                base_sel[l]  = {2'd0, QUARTER_TURN};
            end
            else
            begin
                quad_next[l] = 2'd0;
                base_sel[l]  = 33'd0;
            end
            frac_full[l] = red_reg[l] - base_sel[l];
            xx_next[l]   = {31'd0, x6_reg[l]} * {31'd0, x6_reg[l]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
            f4_vld_reg <= 1'b0;
            f5_vld_reg <= 1'b0;
            f6_vld_reg <= 1'b0;
            f7_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg <= s_axis_tvalid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
            f4_vld_reg <= f3_vld_reg;
            f5_vld_reg <= f4_vld_reg;
            f6_vld_reg <= f5_vld_reg;
            f7_vld_reg <= f6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                ang_reg[l]  <= ang_next[l];
                red_reg[l]  <= red_next[l];
                quad_reg[l] <= quad_next[l];
                frac_reg[l] <= frac_full[l][30:0];
                u4_reg[l]   <= quad_reg[l][0] ? (QUARTER_TURN - frac_reg[l]) : frac_reg[l];
                neg4_reg[l] <= quad_reg[l][1];
                up_reg[l]   <= {30'd0, u4_reg[l]} * {31'd0, RAD_FRAC};
                u5_reg[l]   <= u4_reg[l];
                neg5_reg[l] <= neg4_reg[l];
                x6_reg[l]   <= u5_reg[l] + {3'd0, up_reg[l][60:33]};
                neg6_reg[l] <= neg5_reg[l];
                s7_reg[l]   <= xx_next[l][61:30];
                x7_reg[l]   <= x6_reg[l];
                neg7_reg[l] <= neg6_reg[l];
            end
        end
    end

    // Sine series chains, one per lane
    sin_bus_t sin_link [LANES][SIN_TERMS+1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sin_link[l][0].vld = f7_vld_reg;
            sin_link[l][0].s   = s7_reg[l];
            sin_link[l][0].t   = ONE_Q30;
            sin_link[l][0].x   = x7_reg[l];
            sin_link[l][0].neg = neg7_reg[l];
        end
    end

    for (genvar gl = 0; gl < LANES; gl++)
    begin : g_lane
        for (genvar gj = 0; gj < SIN_TERMS; gj++)
        begin : g_term
            gcdist_sin_cell #(
                .K(SIN_TERMS - gj)
            ) u_sin_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (en),
                .din  (sin_link[gl][gj]),
                .dout (sin_link[gl][gj+1])
            );
        end
    end

    // Sine back end: x*t, clamp, sign
    logic        f8_vld_reg, f9_vld_reg;
    logic [61:0] vp_reg    [LANES];
    logic        neg8_reg  [LANES];
    logic [30:0] mag_reg   [LANES];
    logic        sgn_reg   [LANES];
    logic [61:0] vp_next   [LANES];
    logic [31:0] v_full    [LANES];
    logic [30:0] mag_next  [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            vp_next[l]  = {31'd0, sin_link[l][SIN_TERMS].x} * {31'd0, sin_link[l][SIN_TERMS].t};
            v_full[l]   = vp_reg[l][61:30];
            mag_next[l] = (v_full[l] > {1'b0, ONE_Q30}) ? ONE_Q30 : v_full[l][30:0];
        end
    end

    // Haversine term
    logic        h1_vld_reg, h2_vld_reg, h3_vld_reg;
    logic [30:0] sl2_reg, so2_reg, m_reg, sl2b_reg, term_reg, h_reg;
    logic        hneg_reg, hnegb_reg;
    logic [60:0] sl2_prod, so2_prod, m_prod, term_prod;
    logic [32:0] hs_next;
    logic [30:0] h_next;

    always_comb
    begin
        sl2_prod  = {30'd0, mag_reg[0]} * {30'd0, mag_reg[0]};
        so2_prod  = {30'd0, mag_reg[1]} * {30'd0, mag_reg[1]};
        m_prod    = {30'd0, mag_reg[2]} * {30'd0, mag_reg[3]};
        term_prod = {30'd0, m_reg} * {30'd0, so2_reg};
        hs_next   = hnegb_reg ? ({2'd0, sl2b_reg} - {2'd0, term_reg})
                              : ({2'd0, sl2b_reg} + {2'd0, term_reg});
        if (hs_next[32])
        begin
            h_next = 31'd0;
        end
        else if (hs_next > {2'd0, ONE_Q30})
        begin
            h_next = ONE_Q30;
        end
        else
        begin
            h_next = hs_next[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f8_vld_reg <= 1'b0;
            f9_vld_reg <= 1'b0;
            h1_vld_reg <= 1'b0;
            h2_vld_reg <= 1'b0;
            h3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f8_vld_reg <= sin_link[0][SIN_TERMS].vld;
            f9_vld_reg <= f8_vld_reg;
            h1_vld_reg <= f9_vld_reg;
            h2_vld_reg <= h1_vld_reg;
            h3_vld_reg <= h2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                vp_reg[l]   <= vp_next[l];
                neg8_reg[l] <= sin_link[l][SIN_TERMS].neg;
                mag_reg[l]  <= mag_next[l];
                sgn_reg[l]  <= neg8_reg[l] && (mag_next[l] != 31'd0);
            end
            sl2_reg   <= sl2_prod[60:30];
            so2_reg   <= so2_prod[60:30];
            m_reg     <= m_prod[60:30];
            hneg_reg  <= sgn_reg[2] ^ sgn_reg[3];
            sl2b_reg  <= sl2_reg;
            term_reg  <= term_prod[60:30];
            hnegb_reg <= hneg_reg;
            h_reg     <= h_next;
        end
    end

    // Square roots of h and 1-h
    sqrt_bus_t sqrt_link [SQRT_STEPS+1];
    logic [30:0] one_minus_h;

    always_comb
    begin
        one_minus_h           = ONE_Q30 - h_reg;
        sqrt_link[0].vld      = h3_vld_reg;
        sqrt_link[0].rad_y    = {1'b0, h_reg, 30'd0};
        sqrt_link[0].rad_x    = {1'b0, one_minus_h, 30'd0};
        sqrt_link[0].rem_y    = 33'd0;
        sqrt_link[0].rem_x    = 33'd0;
        sqrt_link[0].root_y   = 31'd0;
        sqrt_link[0].root_x   = 31'd0;
        sqrt_link[0].h        = h_reg;
    end

    for (genvar gs = 0; gs < SQRT_STEPS; gs++)
    begin : g_sqrt
        gcdist_sqrt_cell u_sqrt_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (sqrt_link[gs]),
            .dout (sqrt_link[gs+1])
        );
    end

    // Divider: q = (h << 30) / (2 (1 + x))
    div_bus_t div_link [DIV_STEPS+1];

    always_comb
    begin
        div_link[0].vld = sqrt_link[SQRT_STEPS].vld;
        div_link[0].rem = {2'd0, sqrt_link[SQRT_STEPS].h};
        div_link[0].den = 33'h0_8000_0000 + {1'b0, sqrt_link[SQRT_STEPS].root_x, 1'b0};
        div_link[0].quo = 30'd0;
        div_link[0].y   = sqrt_link[SQRT_STEPS].root_y;
    end

    for (genvar gd = 0; gd < DIV_STEPS; gd++)
    begin : g_div
        gcdist_div_cell u_div_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (div_link[gd]),
            .dout (div_link[gd+1])
        );
    end

    // Arctangent series chain
    atan_bus_t atan_link [ATAN_TERMS+1];

    always_comb
    begin
        atan_link[0].vld = div_link[DIV_STEPS].vld;
        atan_link[0].q   = div_link[DIV_STEPS].quo;
        atan_link[0].t   = ONE_Q30;
        atan_link[0].y   = div_link[DIV_STEPS].y;
    end

    for (genvar ga = 0; ga < ATAN_TERMS; ga++)
    begin : g_atan
        gcdist_atan_cell #(
            .K(ATAN_TERMS - ga)
        ) u_atan_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (atan_link[ga]),
            .dout (atan_link[ga+1])
        );
    end

    // Central angle and radius scaling
    logic        e1_vld_reg, e2_vld_reg;
    logic [61:0] cp_reg;
    logic [54:0] dp_reg;
    logic [61:0] cp_next;
    logic [54:0] dp_next;
    logic [28:0] dist_next;

    always_comb
    begin
        cp_next   = {31'd0, atan_link[ATAN_TERMS].y} * {31'd0, atan_link[ATAN_TERMS].t};
        dp_next   = {32'd0, radius_reg} * {23'd0, cp_reg[60:29]};
        dist_next = dp_reg[54:26];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_vld_reg <= atan_link[ATAN_TERMS].vld;
            e2_vld_reg <= e1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp_reg <= cp_next;
            dp_reg <= dp_next;
        end
    end

    // Two-entry output buffer
    logic        head_vld_reg, skid_vld_reg;
    logic        head_vld_next, skid_vld_next;
    logic [28:0] head_reg, skid_reg;
    logic        pop, push;
    logic        head_load, head_from_skid, skid_load;

    assign en   = !skid_vld_reg || m_axis_tready;
    assign pop  = head_vld_reg && m_axis_tready;
    assign push = e2_vld_reg && en;

    always_comb
    begin
        head_vld_next  = head_vld_reg;
        skid_vld_next  = skid_vld_reg;
        head_load      = 1'b0;
        head_from_skid = 1'b0;
        skid_load      = 1'b0;
        if (pop)
        begin
            if (skid_vld_reg)
            begin
                head_from_skid = 1'b1;
                skid_vld_next  = push;
                skid_load      = push;
            end
            else
            begin
                head_vld_next = push;
                head_load     = push;
            end
        end
        else if (push)
        begin
            if (!head_vld_reg)
            begin
                head_vld_next = 1'b1;
                head_load     = 1'b1;
            end
            else
            begin
                skid_vld_next = 1'b1;
                skid_load     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            head_vld_reg <= head_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_from_skid)
        begin
            head_reg <= skid_reg;
        end
        else if (head_load)
        begin
            head_reg <= dist_next;
        end
        if (skid_load)
        begin
            skid_reg <= dist_next;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = head_vld_reg;
    assign m_axis_tdata  = {3'd0, head_reg};

endmodule

FILE: sv/gcdist_checker.sv
// Port-level checks for the great-circle distance block, bound to the top level.
module gcdist_checker
    import gcdist_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata
);

    // Requests accepted but not yet delivered
    logic [15:0] outstanding_reg;
    logic        in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 16'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + {15'd0, in_acc} - {15'd0, out_acc};
        end
    end

    // A stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

    // Input backpressure only when the output side is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output is free");

    // No result without an accepted request behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> outstanding_reg != 16'd0)
    else $error("result without a pending request");

    // Nothing pending means nothing shows in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 16'd0 |=> !m_axis_tvalid)
    else $error("result appeared with no request in flight");

endmodule

bind great_circle_distance_top gcdist_checker u_gcdist_checker (.*);

FILE: dv/tb.sv
// Testbench for great_circle_distance_top: self-checking haversine distance run.
module tb;
    import gcdist_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QTURN = 64'sd1509949440;
    localparam longint FTURN = 4 * QTURN;
    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned DMAX = 64'h1FFF_FFFF;
    localparam longint DEG = 64'sd8388608;
    localparam int CFG_RADIUS = 0;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 260;

    // Expected distances and the fixed-point haversine predictor
    class distance_scoreboard;
        logic [22:0] radius;
        logic [28:0] dist_q[$];
        int errors;
        int mismatches;

        function new();
            radius = RADIUS_RESET;
            errors = 0;
            mismatches = 0;
        endfunction

        // sine of an angle in 2^-24 degree units, Q30
        function longint sine_q30(longint a);
            longint r, quad, f;
            longint unsigned u, x, s, t, v, d;
            r = a % FTURN;
            if (r < 0)
                r += FTURN;
            quad = r / QTURN;
            f = r - quad * QTURN;
            u = (quad % 2 == 1) ? longint'(QTURN - f) : longint'(f);
            x = (u * 64'd9595049034) >> 33;
            s = (x * x) >> 30;
            t = Q30;
            for (int k = SIN_TERMS; k >= 1; k--)
            begin
                d = longint'(2 * k) * longint'(2 * k + 1);
                t = Q30 - ((s * t) >> 30) / d;
            end
            v = (x * t) >> 30;
            if (v > Q30)
                v = Q30;
            return (quad >= 2) ? -longint'(v) : longint'(v);
        endfunction

        function longint unsigned abs64(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function logic [28:0] distance_of(logic [127:0] req);
            longint lat_a, lon_a, lat_b, lon_b, sl, so, ca, cb, hs;
            longint unsigned sl2, so2, m, term, h, y, x, q, t, c, d;
            lat_a = longint'($signed(req[30:0]));
            lon_a = longint'($signed(req[62:31]));
            lat_b = longint'($signed(req[93:63]));
            lon_b = longint'($signed(req[125:94]));
            sl = sine_q30(lat_b - lat_a);
            so = sine_q30(lon_b - lon_a);
            ca = sine_q30(2 * lat_a + QTURN);
            cb = sine_q30(2 * lat_b + QTURN);
            sl2 = (abs64(sl) * abs64(sl)) >> 30;
            so2 = (abs64(so) * abs64(so)) >> 30;
            m = (abs64(ca) * abs64(cb)) >> 30;
            term = (m * so2) >> 30;
            hs = ((ca < 0) != (cb < 0)) ? longint'(sl2) - longint'(term)
                                        : longint'(sl2) + longint'(term);
            // clamp the haversine term to [0,1]
            if (hs < 0)
                hs = 0;
            if (hs > longint'(Q30))
                hs = longint'(Q30);
            h = hs;
            y = floor_sqrt(h << 30);
            x = floor_sqrt((Q30 - h) << 30);
            q = (h << 30) / (2 * (Q30 + x));
            t = Q30;
            for (int k = ATAN_TERMS; k >= 1; k--)
                t = Q30 + (((q * t) >> 30) * longint'(2 * k)) / longint'(2 * k + 1);
            c = (y * t) >> 29;
            d = (longint'(radius) * c) >> 26;
            if (d > DMAX)
                d = DMAX;
            return d[28:0];
        endfunction

        function void note_request(logic [127:0] req);
            dist_q.push_back(distance_of(req));
        endfunction

        function void check_result(logic [31:0] data);
            logic [28:0] exp_d;
            if (dist_q.size() == 0)
            begin
                errors++;
                $display("unexpected result: distance %0d", data[28:0]);
                return;
            end
            exp_d = dist_q.pop_front();
            if (data[28:0] !== exp_d || data[31:29] !== 3'b0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("distance mismatch: expected %0d, got %0d (pad %b)",
                             exp_d, data[28:0], data[31:29]);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [22:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;

    distance_scoreboard dist_sb;
    int stall_mode;
    int gap_mode;
    int idle_cycles;

    great_circle_distance_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function logic [127:0] pack_req(longint lat_a, longint lon_a, longint lat_b, longint lon_b);
        return {2'b00, lon_b[31:0], lat_b[30:0], lon_a[31:0], lat_a[30:0]};
    endfunction

    // Handshakes are judged at the falling edge, where all inputs are settled
    task automatic send_request(logic [127:0] req);
        logic acc;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        do
        begin
            @(negedge clk);
            acc = s_axis_tready;
            @(posedge clk);
        end
        while (!acc);
        dist_sb.note_request(req);
    endtask

    task automatic write_radius(logic [22:0] value);
        logic acc;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            acc = cfg_ready;
            @(posedge clk);
        end
        while (!acc);
        cfg_valid <= 1'b0;
        dist_sb.radius = value;
    endtask

    // Wait for every expected distance, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (dist_sb.dist_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function longint rand_lat();
        if ($urandom_range(0, 9) == 0)
            return longint'($signed(31'($urandom())));
        return longint'($urandom_range(0, 1509949440)) - 64'sd754974720;
    endfunction

    function longint rand_lon();
        if ($urandom_range(0, 9) == 0)
            return longint'($signed($urandom()));
        return longint'($urandom_range(0, 32'd3019898880)) - 64'sd1509949440;
    endfunction

    // Random positions, sent in bursts; some pairs lie close together
    task automatic random_requests(int count);
        int burst;
        int gap;
        longint la, lo;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 30);
                if (gap_mode != 0)
                begin
                    gap = $urandom_range(0, 15);
                    // a zero gap keeps valid high into the next burst
                    if (gap != 0)
                    begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
            burst--;
            la = rand_lat();
            lo = rand_lon();
            if ($urandom_range(0, 3) == 0)
                send_request(pack_req(la, lo, la + longint'($urandom_range(0, 4096)) - 2048,
                                      lo + longint'($urandom_range(0, 65536)) - 32768));
            else
                send_request(pack_req(la, lo, rand_lat(), rand_lon()));
        end
    endtask

    // Extremes, identical points, poles, antipodes and out-of-range angles
    task automatic directed_requests();
        send_request(pack_req(0, 0, 0, 0));
        send_request(pack_req(90 * DEG, 180 * DEG, 90 * DEG, 180 * DEG));
        send_request(pack_req(0, 0, 0, 180 * DEG));
        send_request(pack_req(0, -180 * DEG, 0, 180 * DEG));
        send_request(pack_req(90 * DEG, 0, -90 * DEG, 0));
        send_request(pack_req(-90 * DEG, -180 * DEG, 90 * DEG, 180 * DEG));
        send_request(pack_req(45 * DEG, 10 * DEG, -45 * DEG, -170 * DEG));
        send_request(pack_req(0, 0, 0, 1));
        send_request(pack_req(1, 0, 0, 0));
        send_request(pack_req(-64'sd1073741824, -64'sd2147483648, 64'sd1073741823,
                              64'sd2147483647));
        send_request(pack_req(64'sd1073741823, 64'sd2147483647, -64'sd1073741824,
                              -64'sd2147483648));
        send_request(pack_req(120 * DEG, 0, -120 * DEG, 90 * DEG));
        send_request(pack_req(51 * DEG, 0, 40 * DEG, -74 * DEG));
        send_request(pack_req(89 * DEG, 0, 89 * DEG, 180 * DEG));
        send_request(pack_req(-30 * DEG, 170 * DEG, -30 * DEG, -170 * DEG));
        send_request(pack_req(0, 90 * DEG, 0, -90 * DEG));
        send_request(pack_req(10 * DEG, 20 * DEG, 10 * DEG + 7, 20 * DEG + 9));
    endtask

    // Result side: stall pattern depends on stall_mode
    initial
    begin
        logic acc;
        logic [31:0] data;
        int cyc;
        m_axis_tready = 1'b0;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            acc = m_axis_tvalid && m_axis_tready;
            data = m_axis_tdata;
            if (acc || (s_axis_tvalid && s_axis_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            @(posedge clk);
            if (acc)
                dist_sb.check_result(data);
            cyc++;
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 9) < 7);
                2: m_axis_tready <= (cyc % 16 < 5);
                default: m_axis_tready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // Watchdog on cycles with no accepted transfer
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        dist_sb = new();
        stall_mode = 0;
        gap_mode = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset radius
        directed_requests();
        random_requests(150);
        stall_mode = 1;
        gap_mode = 1;
        random_requests(300);
        drain();

        write_radius(23'd1);
        stall_mode = 2;
        random_requests(200);
        drain();

        write_radius(23'h7F_FFFF);
        stall_mode = 3;
        gap_mode = 0;
        directed_requests();
        random_requests(250);
        drain();

        write_radius(23'd0);
        stall_mode = 1;
        gap_mode = 1;
        random_requests(150);
        drain();

        write_radius(23'd6371000);
        stall_mode = 0;
        gap_mode = 0;
        random_requests(200);
        stall_mode = 1;
        gap_mode = 1;
        random_requests(350);
        drain();

        if (dist_sb.errors == 0 && dist_sb.dist_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: sim.f
sv/gcdist_pkg.sv
sv/gcdist_sin_cell.sv
sv/gcdist_sqrt_cell.sv
sv/gcdist_div_cell.sv
sv/gcdist_atan_cell.sv
sv/great_circle_distance_top.sv
sv/gcdist_checker.sv
dv/tb.sv
